/* rtl/core/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 34;
  localparam int PAY_W  = 16;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  // Request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/spq_if.sv */
// Request and result channel interfaces of the sorted priority queue.
`default_nettype none
interface spq_req_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [spq_pkg::KEY_W-1:0] key_in;
  logic [spq_pkg::PAY_W-1:0] payload_in;

  modport source (output valid, mode, key_in, payload_in, input ready);
  modport sink   (input valid, mode, key_in, payload_in, output ready);
endinterface

interface spq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [spq_pkg::STAT_W-1:0] status;
  logic [spq_pkg::KEY_W-1:0]  key_out;
  logic [spq_pkg::PAY_W-1:0]  payload_out;
  logic [spq_pkg::FILL_W-1:0] fill;

  modport source (output valid, status, key_out, payload_out, fill, input ready);
  modport sink   (input valid, status, key_out, payload_out, fill, output ready);
endinterface
`default_nettype wire

/* rtl/core/sorted_priority_queue_top.sv */
// Sorted priority queue: a two-port entry memory walked by one key comparator.
// Entries are held in ascending key order, front at address 0; an insert lands
// after every entry with a smaller or equal key, so equal keys leave in arrival
// order. One request is in flight at a time and req.ready is low while it runs.
// An insert into a non-empty queue walks from the back, moving each stored entry
// whose key is greater than the new key up one place and writing the new entry
// into the gap; a remove moves every other entry down one place toward the front.
// An insert into an empty or a full queue, or a remove from an empty one, needs
// no walk. The memory reads and writes one entry per cycle as the comparator checks
// it. The finished result sits in an output register until the sink takes it.
`default_nettype none
module sorted_priority_queue_top (
  input  wire        clk,
  input  wire        rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_REM_HEAD = 3'd3;
  localparam logic [2:0] S_REM      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]                 state, state_next;
  logic [spq_pkg::CNT_W-1:0]  count, count_next;
  logic [spq_pkg::IDX_W-1:0]  ptr, ptr_next;
  spq_pkg::entry_t            item, item_next;
  spq_pkg::entry_t            res_entry, res_entry_next;
  logic [spq_pkg::STAT_W-1:0] res_status, res_status_next;

  // Entry memory: one write, one registered read per cycle
  spq_pkg::entry_t            mem [spq_pkg::DEPTH];
  spq_pkg::entry_t            rd_data;
  logic [spq_pkg::IDX_W-1:0]  rd_addr;
  logic [spq_pkg::IDX_W-1:0]  wr_addr;
  spq_pkg::entry_t            wr_data;
  logic                       wr_en;

  logic                       greater;
  logic                       last_rem;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Shared comparator: does the stored entry move past the new key
  assign greater  = rd_data.key > item.key;
  assign last_rem = spq_pkg::CNT_W'(ptr) == count - spq_pkg::CNT_W'(1);

  assign req.ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    item_next       = item;
    res_entry_next  = res_entry;
    res_status_next = res_status;
    rd_addr         = ptr;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_data         = item;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          item_next      = '{key: req.key_in, payload: req.payload_in};
          res_entry_next = '0;
          if (req.mode == spq_pkg::MODE_INSERT) begin
            priority if (count == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
              res_status_next = spq_pkg::ST_FULL;
              state_next      = S_DONE;
            end else if (count == '0) begin
              wr_en           = 1'b1;
              wr_addr         = '0;
              wr_data         = '{key: req.key_in, payload: req.payload_in};
              count_next      = count + spq_pkg::CNT_W'(1);
              res_status_next = spq_pkg::ST_INSERTED;
              state_next      = S_DONE;
            end else begin
              ptr_next   = spq_pkg::IDX_W'(count - spq_pkg::CNT_W'(1));
              rd_addr    = spq_pkg::IDX_W'(count - spq_pkg::CNT_W'(1));
              state_next = S_INS;
            end
          end else begin
            if (count == '0) begin
              res_status_next = spq_pkg::ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              ptr_next   = '0;
              rd_addr    = '0;
              state_next = S_REM_HEAD;
            end
          end
        end
      end
      S_INS: begin
        // Shift larger entries up one place, drop the new one into the gap
        if (greater) begin
          wr_en   = 1'b1;
          wr_addr = ptr + spq_pkg::IDX_W'(1);
          wr_data = rd_data;
          if (ptr == '0) begin
            state_next = S_INS_LAST;
          end else begin
            ptr_next = ptr - spq_pkg::IDX_W'(1);
            rd_addr  = ptr - spq_pkg::IDX_W'(1);
          end
        end else begin
          wr_en           = 1'b1;
          wr_addr         = ptr + spq_pkg::IDX_W'(1);
          count_next      = count + spq_pkg::CNT_W'(1);
          res_status_next = spq_pkg::ST_INSERTED;
          state_next      = S_DONE;
        end
      end
      S_INS_LAST: begin
        wr_en           = 1'b1;
        wr_addr         = '0;
        count_next      = count + spq_pkg::CNT_W'(1);
        res_status_next = spq_pkg::ST_INSERTED;
        state_next      = S_DONE;
      end
      S_REM_HEAD: begin
        res_entry_next  = rd_data;
        res_status_next = spq_pkg::ST_REMOVED;
        if (count == spq_pkg::CNT_W'(1)) begin
          count_next = '0;
          state_next = S_DONE;
        end else begin
          ptr_next   = spq_pkg::IDX_W'(1);
          rd_addr    = spq_pkg::IDX_W'(1);
          state_next = S_REM;
        end
      end
      S_REM: begin
        // Move each entry down one place toward the front
        wr_en   = 1'b1;
        wr_addr = ptr - spq_pkg::IDX_W'(1);
        wr_data = rd_data;
        if (last_rem) begin
          count_next = count - spq_pkg::CNT_W'(1);
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + spq_pkg::IDX_W'(1);
          rd_addr  = ptr + spq_pkg::IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    item       <= item_next;
    res_entry  <= res_entry_next;
    res_status <= res_status_next;
  end

  // Result register: load when done and the slot is free, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status      <= res_status;
      rsp.key_out     <= res_entry.key;
      rsp.payload_out <= res_entry.payload;
      rsp.fill        <= spq_pkg::FILL_W'(count);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to its top level.
`default_nettype none
module spq_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire [spq_pkg::STAT_W-1:0] status,
  input wire [spq_pkg::KEY_W-1:0]  key_out,
  input wire [spq_pkg::PAY_W-1:0]  payload_out,
  input wire [spq_pkg::FILL_W-1:0] fill
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill))
    else $error("result changed while stalled");

  // One request at a time: not ready right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // An insert result carries no entry and leaves at least one held
  a_ins: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_INSERTED |->
      fill != '0 && key_out == '0 && payload_out == '0)
    else $error("bad insert result");

  // An empty remove reports nothing held
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |->
      fill == '0 && key_out == '0 && payload_out == '0)
    else $error("bad empty result");

  // A full report shows the full count
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_FULL |->
      fill == spq_pkg::FILL_W'(spq_pkg::DEPTH))
    else $error("bad full result");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .status      (rsp.status),
  .key_out     (rsp.key_out),
  .payload_out (rsp.payload_out),
  .fill        (rsp.fill)
);
`default_nettype wire

/* dv/sorted_priority_queue_top_tb.sv */
// Self-checking testbench for the sorted priority queue: ordered insert, remove and tie order.
`timescale 1ns / 100ps
module sorted_priority_queue_top_tb;

  typedef struct {
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::KEY_W-1:0]  key;
    logic [spq_pkg::PAY_W-1:0]  payload;
    logic [spq_pkg::FILL_W-1:0] fill;
  } queue_result_t;

  // Shadow copy of the queue; predicts each result and checks it on arrival.
  class queue_scoreboard;
    logic [spq_pkg::KEY_W-1:0] keys [spq_pkg::DEPTH];
    logic [spq_pkg::PAY_W-1:0] tags [spq_pkg::DEPTH];
    int unsigned      held;
    queue_result_t    awaited[$];
    int unsigned      errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the shadow queue and store its result.
    function void note_request(logic mode, logic [spq_pkg::KEY_W-1:0] key,
                               logic [spq_pkg::PAY_W-1:0] tag);
      queue_result_t res;
      int unsigned   pos;
      res.status  = spq_pkg::ST_INSERTED;
      res.key     = '0;
      res.payload = '0;
      if (mode == spq_pkg::MODE_INSERT) begin
        if (held >= spq_pkg::DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          // land after every entry with a smaller or equal key
          pos = 0;
          while (pos < held && keys[pos] <= key) pos++;
          for (int i = held; i > pos; i--) begin
            keys[i] = keys[i-1];
            tags[i] = tags[i-1];
          end
          keys[pos] = key;
          tags[pos] = tag;
          held++;
        end
      end else begin
        if (held == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          res.status  = spq_pkg::ST_REMOVED;
          res.key     = keys[0];
          res.payload = tags[0];
          for (int i = 1; i < held; i++) begin
            keys[i-1] = keys[i];
            tags[i-1] = tags[i];
          end
          held--;
        end
      end
      res.fill = spq_pkg::FILL_W'(held);
      awaited.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Compare one result transfer against the oldest prediction.
    task check_result(queue_result_t got);
      queue_result_t exp;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, status %0d", got.status));
      end else begin
        exp = awaited.pop_front();
        if (got.status !== exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
        if (got.key !== exp.key)
          report_mismatch($sformatf("key_out %0d, expected %0d", got.key, exp.key));
        if (got.payload !== exp.payload)
          report_mismatch($sformatf("payload_out %h, expected %h", got.payload, exp.payload));
        if (got.fill !== exp.fill)
          report_mismatch($sformatf("fill %0d, expected %0d", got.fill, exp.fill));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  queue_scoreboard sb;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none during quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Favor small keys so ties are frequent; cover extremes and the full 34 bits.
  function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
    int          r;
    logic [63:0] wide;
    r = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (r < 4) return spq_pkg::KEY_W'($urandom_range(0, 7));
    if (r == 4) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return '1;
        default: return 34'd9999999999;
      endcase
    end
    if (r < 8) return spq_pkg::KEY_W'(wide % 64'd10000000000);
    return wide[spq_pkg::KEY_W-1:0];
  endfunction

  // Present one request after a random gap and hold it until the transfer.
  task automatic send_request(logic mode, logic [spq_pkg::KEY_W-1:0] key,
                              logic [spq_pkg::PAY_W-1:0] tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.key_in     <= key;
    req_ch.payload_in <= tag;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(mode, key, tag);
  endtask

  // Result side: check each transfer, stall ready at random.
  initial begin
    int stall_left;
    queue_result_t got;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.status  = rsp_ch.status;
        got.key     = rsp_ch.key_out;
        got.payload = rsp_ch.payload_out;
        got.fill    = rsp_ch.fill;
        sb.check_result(got);
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Stimulus: directed corner cases, then phases that swing between full and empty.
  initial begin
    int sent;
    int phase_len;
    int insert_pct;
    sb                = new();
    no_idle           = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = spq_pkg::MODE_INSERT;
    req_ch.key_in     = '0;
    req_ch.payload_in = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // remove from empty, key extremes, ties at front and back
    send_request(spq_pkg::MODE_REMOVE, '1, '1);
    send_request(spq_pkg::MODE_INSERT, '0, 16'hFFFF);
    send_request(spq_pkg::MODE_INSERT, '1, 16'h0000);
    send_request(spq_pkg::MODE_INSERT, '1, 16'h0001);
    send_request(spq_pkg::MODE_INSERT, 34'd9999999999, 16'hAAAA);
    send_request(spq_pkg::MODE_INSERT, '0, 16'h5555);
    send_request(spq_pkg::MODE_INSERT, 34'h200000000, 16'h1234);
    send_request(spq_pkg::MODE_INSERT, 34'h1, 16'h8000);
    for (int i = 0; i < 8; i++) send_request(spq_pkg::MODE_REMOVE, '0, '0);

    // fill-heavy, drain-heavy and balanced phases, some without idling
    sent = 0;
    while (sent < 700) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < insert_pct)
          send_request(spq_pkg::MODE_INSERT, pick_key(),
                       spq_pkg::PAY_W'($urandom_range(0, 65535)));
        else
          send_request(spq_pkg::MODE_REMOVE, pick_key(),
                       spq_pkg::PAY_W'($urandom_range(0, 65535)));
        sent++;
      end
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    // drain outstanding results, then allow a longest operation to settle
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.awaited.size() != 0) sb.report_mismatch("results left unanswered at end");
    if (sb.errors == 0) begin
      $display("sorted_priority_queue_top_tb: done, clean");
    end else begin
      $display("sorted_priority_queue_top_tb: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("sorted_priority_queue_top_tb: done, errors");
    $finish;
  end

endmodule
